>>> hdl/ps2mc_pkg.sv
`default_nettype none

package ps2mc_pkg;

    localparam int COORD_BITS_DEFAULT  = 12;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int CFG_BITS   = 13;
    localparam int BYTE_BITS  = 8;
    localparam int SET_BITS   = 12;
    localparam int OUT_BITS   = 12;
    localparam int KIND_BITS  = 2;
    localparam int BTN_BITS   = 2;
    localparam int NUM_BTNS   = 3;
    localparam int NUM_SLOTS  = 1 + 3 * NUM_BTNS;
    localparam int SLOT_BITS  = 4;
    // Wide enough to hold any coordinate width up to 16 plus the value 2**16.
    localparam int EXT_BITS   = 17;

    localparam logic [CFG_BITS-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [CFG_BITS-1:0] RESET_HEIGHT = 13'd480;

    // Configuration register indexes.
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // Event kinds.
    localparam logic [KIND_BITS-1:0] EV_MOVE  = 2'd0;
    localparam logic [KIND_BITS-1:0] EV_DOWN  = 2'd1;
    localparam logic [KIND_BITS-1:0] EV_UP    = 2'd2;
    localparam logic [KIND_BITS-1:0] EV_CLICK = 2'd3;

    // Bit positions in the flags byte.
    localparam int FLAG_SYNC   = 3;
    localparam int FLAG_X_SIGN = 4;
    localparam int FLAG_Y_SIGN = 5;
    localparam int FLAG_X_OVF  = 6;
    localparam int FLAG_Y_OVF  = 7;

    typedef struct packed {
        logic                 is_set;
        logic [BYTE_BITS-1:0] flags;
        logic [BYTE_BITS-1:0] x_byte;
        logic [BYTE_BITS-1:0] y_byte;
        logic [SET_BITS-1:0]  set_x;
        logic [SET_BITS-1:0]  set_y;
    } t_cmd;

    // Event slot 0 is the move; button i owns slots 1+3i (down), 2+3i (up), 3+3i (click).
    function automatic logic [KIND_BITS-1:0] slot_kind(input logic [SLOT_BITS-1:0] slot);
        logic [KIND_BITS-1:0] k;
        case (slot)
            4'd1, 4'd4, 4'd7: k = EV_DOWN;
            4'd2, 4'd5, 4'd8: k = EV_UP;
            4'd3, 4'd6, 4'd9: k = EV_CLICK;
            default:          k = EV_MOVE;
        endcase
        return k;
    endfunction

    function automatic logic [BTN_BITS-1:0] slot_btn(input logic [SLOT_BITS-1:0] slot);
        logic [BTN_BITS-1:0] b;
        case (slot)
            4'd4, 4'd5, 4'd6: b = 2'd1;
            4'd7, 4'd8, 4'd9: b = 2'd2;
            default:          b = 2'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> hdl/ps2mc_front.sv
`default_nettype none

module ps2mc_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_op,
    input  wire logic [ps2mc_pkg::BYTE_BITS-1:0] i_data_byte,
    input  wire logic [ps2mc_pkg::SET_BITS-1:0]  i_set_x,
    input  wire logic [ps2mc_pkg::SET_BITS-1:0]  i_set_y,
    input  wire logic                           i_q_full,
    output logic                                o_push,
    output ps2mc_pkg::t_cmd                     o_cmd
);
    import ps2mc_pkg::*;

    localparam logic [1:0] IDX_FLAGS = 2'd0;
    localparam logic [1:0] IDX_X     = 2'd1;
    localparam logic [1:0] IDX_Y     = 2'd2;

    logic [1:0]           r_byte_idx, n_byte_idx;
    logic [BYTE_BITS-1:0] r_flags, n_flags;
    logic [BYTE_BITS-1:0] r_x_byte, n_x_byte;
    logic                 accept;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid & ~i_q_full;

    always_comb begin
        n_byte_idx = r_byte_idx;
        n_flags    = r_flags;
        n_x_byte   = r_x_byte;
        o_push     = 1'b0;
        if (accept) begin
            if (i_op) begin
                o_push = 1'b1;
            end else begin
                case (r_byte_idx)
                    IDX_X: begin
                        n_x_byte   = i_data_byte;
                        n_byte_idx = IDX_Y;
                    end
                    IDX_Y: begin
                        n_byte_idx = IDX_FLAGS;
                        o_push     = 1'b1;
                    end
                    default: begin
                        // A packet can only start on a byte with the sync bit set.
                        n_byte_idx = IDX_FLAGS;
                        if (i_data_byte[FLAG_SYNC]) begin
                            n_flags    = i_data_byte;
                            n_byte_idx = IDX_X;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_cmd.is_set = i_op;
        o_cmd.flags  = r_flags;
        o_cmd.x_byte = r_x_byte;
        o_cmd.y_byte = i_data_byte;
        o_cmd.set_x  = i_set_x;
        o_cmd.set_y  = i_set_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx <= IDX_FLAGS;
        end else begin
            r_byte_idx <= n_byte_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags  <= n_flags;
        r_x_byte <= n_x_byte;
    end

endmodule

`default_nettype wire

>>> hdl/ps2mc_queue.sv
`default_nettype none

module ps2mc_queue #(
    parameter int DEPTH = ps2mc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ps2mc_pkg::t_cmd i_cmd,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output ps2mc_pkg::t_cmd      o_head
);
    import ps2mc_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    t_cmd                r_entries [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_entries[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> hdl/ps2mc_back.sv
`default_nettype none

module ps2mc_back #(
    parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_empty,
    input  wire ps2mc_pkg::t_cmd                 i_head,
    output logic                                 o_pop,
    input  wire logic [ps2mc_pkg::CFG_BITS-1:0]  i_screen_width,
    input  wire logic [ps2mc_pkg::CFG_BITS-1:0]  i_screen_height,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [ps2mc_pkg::KIND_BITS-1:0]      o_event_kind,
    output logic [ps2mc_pkg::OUT_BITS-1:0]       o_cursor_x,
    output logic [ps2mc_pkg::OUT_BITS-1:0]       o_cursor_y,
    output logic [ps2mc_pkg::BTN_BITS-1:0]       o_button_index,
    output logic                                 o_last_event
);
    import ps2mc_pkg::*;

    localparam int W = COORD_BITS;
    localparam int CAP = 1 << COORD_BITS;
    localparam int RST_LIM_X = ((int'(RESET_WIDTH) > CAP) ? CAP : int'(RESET_WIDTH)) - 1;
    localparam int RST_LIM_Y = ((int'(RESET_HEIGHT) > CAP) ? CAP : int'(RESET_HEIGHT)) - 1;
    localparam int RST_X = (RST_LIM_X > int'(RESET_WIDTH) / 2) ? int'(RESET_WIDTH) / 2
                                                               : RST_LIM_X;
    localparam int RST_Y = (RST_LIM_Y > int'(RESET_HEIGHT) / 2) ? int'(RESET_HEIGHT) / 2
                                                                : RST_LIM_Y;

    function automatic logic [W-1:0] axis_limit(input logic [CFG_BITS-1:0] size);
        logic [EXT_BITS-1:0] sz;
        logic [EXT_BITS-1:0] cap;
        sz  = EXT_BITS'(size);
        cap = EXT_BITS'(1) << W;
        if (sz == '0) begin
            sz = EXT_BITS'(1);
        end
        if (sz > cap) begin
            sz = cap;
        end
        sz = sz - EXT_BITS'(1);
        return sz[W-1:0];
    endfunction

    function automatic logic [W-1:0] move_axis(input logic [W-1:0] pos,
                                               input logic signed [9:0] delta,
                                               input logic [W-1:0] lim);
        logic signed [W+1:0] sum;
        logic [W-1:0]        res;
        sum = $signed({2'b00, pos}) + (W+2)'(delta);
        if (sum < 0) begin
            res = '0;
        end else if (sum > $signed({2'b00, lim})) begin
            res = lim;
        end else begin
            res = sum[W-1:0];
        end
        return res;
    endfunction

    logic [W-1:0]          r_pos_x, n_pos_x;
    logic [W-1:0]          r_pos_y, n_pos_y;
    logic [NUM_BTNS-1:0]   r_buttons, n_buttons;
    logic [NUM_SLOTS-1:0]  r_mask, n_mask;

    logic                  r_out_valid;
    logic [KIND_BITS-1:0]  r_kind;
    logic [BTN_BITS-1:0]   r_btn;
    logic [OUT_BITS-1:0]   r_out_x, r_out_y;
    logic                  r_last;

    logic                  out_free, emit, can_take;
    logic [NUM_SLOTS-1:0]  low_bit, rest;
    logic [SLOT_BITS-1:0]  slot;
    logic [NUM_BTNS-1:0]   new_btns, pressed, released;
    logic [NUM_SLOTS-1:0]  pkt_mask;
    logic signed [9:0]     dx, dy, y_raw;
    logic [EXT_BITS-1:0]   pos_x_ext, pos_y_ext, set_x_ext, set_y_ext;

    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = (r_mask != '0) && out_free;
    assign low_bit  = r_mask & (~r_mask + 1'b1);
    assign rest     = r_mask & ~low_bit;
    // The next command may be taken while the last event of this one leaves.
    assign can_take = (r_mask == '0) || (emit && rest == '0);
    assign o_pop    = !i_empty && can_take;

    assign pos_x_ext = EXT_BITS'(r_pos_x);
    assign pos_y_ext = EXT_BITS'(r_pos_y);
    assign set_x_ext = EXT_BITS'(i_head.set_x);
    assign set_y_ext = EXT_BITS'(i_head.set_y);

    always_comb begin
        slot = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (r_mask[s]) begin
                slot = SLOT_BITS'(s);
            end
        end
    end

    always_comb begin
        dx = i_head.flags[FLAG_X_OVF] ? 10'sd0
           : $signed({{2{i_head.flags[FLAG_X_SIGN]}}, i_head.x_byte});
        y_raw = $signed({{2{i_head.flags[FLAG_Y_SIGN]}}, i_head.y_byte});
        // Mouse Y grows upward, screen rows grow downward.
        dy = i_head.flags[FLAG_Y_OVF] ? 10'sd0 : -y_raw;

        new_btns = i_head.flags[NUM_BTNS-1:0];
        pressed  = ~r_buttons & new_btns;
        released = r_buttons & ~new_btns;
        pkt_mask = '0;
        pkt_mask[0] = 1'b1;
        for (int i = 0; i < NUM_BTNS; i++) begin
            pkt_mask[1 + 3*i] = pressed[i];
            pkt_mask[2 + 3*i] = released[i];
            pkt_mask[3 + 3*i] = released[i];
        end
    end

    always_comb begin
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_buttons = r_buttons;
        n_mask    = emit ? rest : r_mask;
        if (o_pop) begin
            if (i_head.is_set) begin
                n_pos_x = set_x_ext[W-1:0];
                n_pos_y = set_y_ext[W-1:0];
            end else begin
                n_pos_x   = move_axis(r_pos_x, dx, axis_limit(i_screen_width));
                n_pos_y   = move_axis(r_pos_y, dy, axis_limit(i_screen_height));
                n_buttons = new_btns;
                n_mask    = pkt_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= W'(RST_X);
            r_pos_y     <= W'(RST_Y);
            r_buttons   <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_buttons <= n_buttons;
            r_mask    <= n_mask;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind  <= slot_kind(slot);
            r_btn   <= slot_btn(slot);
            r_out_x <= pos_x_ext[OUT_BITS-1:0];
            r_out_y <= pos_y_ext[OUT_BITS-1:0];
            r_last  <= (rest == '0);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_kind;
    assign o_cursor_x     = r_out_x;
    assign o_cursor_y     = r_out_y;
    assign o_button_index = r_btn;
    assign o_last_event   = r_last;

endmodule

`default_nettype wire

>>> hdl/ps2_mouse_packet_to_cursor_events.sv
`default_nettype none

// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   i_op, i_data_byte, i_set_x, i_set_y
// out      output     o_out_valid / i_out_stall o_event_kind, o_cursor_x, o_cursor_y,
//                                               o_button_index, o_last_event
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An input byte is taken every cycle while the command queue has room.
// A full packet or a set-position command is queued; the back end takes it from the
// queue and, for a packet, emits one event per cycle while the output is not stalled,
// 1 to 7 events per packet, the next command being taken while the last event of the
// previous one moves into the output register. A set-position command emits no event.
// Reset is synchronous; after it no pass over any storage is needed.
// A stall on the output holds the event register; the queue then fills and stalls input.

module ps2_mouse_packet_to_cursor_events #(
    parameter int COORD_BITS  = ps2mc_pkg::COORD_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = ps2mc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_op,
    input  wire logic [ps2mc_pkg::BYTE_BITS-1:0] i_data_byte,
    input  wire logic [ps2mc_pkg::SET_BITS-1:0]  i_set_x,
    input  wire logic [ps2mc_pkg::SET_BITS-1:0]  i_set_y,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [ps2mc_pkg::KIND_BITS-1:0]      o_event_kind,
    output logic [ps2mc_pkg::OUT_BITS-1:0]       o_cursor_x,
    output logic [ps2mc_pkg::OUT_BITS-1:0]       o_cursor_y,
    output logic [ps2mc_pkg::BTN_BITS-1:0]       o_button_index,
    output logic                                 o_last_event,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic                            i_cfg_index,
    input  wire logic [ps2mc_pkg::CFG_BITS-1:0]  i_cfg_data
);
    import ps2mc_pkg::*;

    logic [CFG_BITS-1:0] r_screen_width;
    logic [CFG_BITS-1:0] r_screen_height;
    logic                q_full, q_empty, push, pop;
    t_cmd                push_cmd, head_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= RESET_WIDTH;
            r_screen_height <= RESET_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ps2mc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_set_x     (i_set_x),
        .i_set_y     (i_set_y),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    ps2mc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    ps2mc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_head          (head_cmd),
        .o_pop           (pop),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_kind    (o_event_kind),
        .o_cursor_x      (o_cursor_x),
        .o_cursor_y      (o_cursor_y),
        .o_button_index  (o_button_index),
        .o_last_event    (o_last_event)
    );

endmodule

`default_nettype wire

>>> hdl/ps2mc_checker.sv
`default_nettype none

module ps2mc_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic [ps2mc_pkg::KIND_BITS-1:0] o_event_kind,
    input wire logic [ps2mc_pkg::OUT_BITS-1:0]  o_cursor_x,
    input wire logic [ps2mc_pkg::OUT_BITS-1:0]  o_cursor_y,
    input wire logic [ps2mc_pkg::BTN_BITS-1:0]  o_button_index,
    input wire logic                            o_last_event
);
    import ps2mc_pkg::*;

    logic                 xfer;
    logic                 r_prev_last;
    logic [KIND_BITS-1:0] r_prev_kind;
    logic [BTN_BITS-1:0]  r_prev_btn;
    logic [OUT_BITS-1:0]  r_prev_x, r_prev_y;

    assign xfer = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_last <= 1'b1;
            r_prev_kind <= EV_MOVE;
        end else if (xfer) begin
            r_prev_last <= o_last_event;
            r_prev_kind <= o_event_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_prev_btn <= o_button_index;
            r_prev_x   <= o_cursor_x;
            r_prev_y   <= o_cursor_y;
        end
    end

    // A stalled event holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_event_kind)
            && $stable(o_cursor_x) && $stable(o_cursor_y)
            && $stable(o_button_index) && $stable(o_last_event))
        else $error("stalled event changed");

    // Every packet opens with exactly one move event.
    a_move_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer |-> (r_prev_last == (o_event_kind == EV_MOVE)))
        else $error("move event out of place");

    // A click directly follows the up event of the same button.
    a_click_after_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && o_event_kind == EV_CLICK |-> r_prev_kind == EV_UP
            && r_prev_btn == o_button_index)
        else $error("click without matching up event");

    // The cursor stays fixed across the events of one packet.
    a_cursor_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && !r_prev_last |-> o_cursor_x == r_prev_x && o_cursor_y == r_prev_y)
        else $error("cursor moved within a packet");

endmodule

bind ps2_mouse_packet_to_cursor_events ps2mc_checker u_ps2mc_checker (.*);

`default_nettype wire
